FILE: src/skpt_pkg.sv
// ----------------------------------------------------------------------------
// skpt_pkg
// Shared types and constants of the sorted keyed property table.
// ----------------------------------------------------------------------------
`default_nettype none
package skpt_pkg;
  localparam int unsigned TableDepth  = 64;
  localparam int unsigned PayloadBits = 64;
  localparam int unsigned IdxW        = $clog2(TableDepth);
  localparam int unsigned CntW        = $clog2(TableDepth + 1);
  // entry word: key, payload, type, flags
  localparam int unsigned EntryW      = 32 + PayloadBits + 32 + 16;

  localparam logic [15:0] FlagNonplain = 16'h0008;
  localparam logic [15:0] FlagLock     = 16'h0002;
  localparam logic [15:0] FlagKeepMask = 16'hfffd;

  localparam logic [1:0] ReqSet    = 2'd0;
  localparam logic [1:0] ReqRemove = 2'd1;
  localparam logic [1:0] ReqLookup = 2'd2;
  localparam logic [1:0] ReqClear  = 2'd3;

  localparam logic [2:0] StOk       = 3'd0;
  localparam logic [2:0] StInserted = 3'd1;
  localparam logic [2:0] StRemoved  = 3'd2;
  localparam logic [2:0] StNotFound = 3'd3;
  localparam logic [2:0] StFull     = 3'd4;
  localparam logic [2:0] StConvert  = 3'd5;

  typedef struct packed {
    logic [31:0]            key;
    logic [PayloadBits-1:0] payload;
    logic [31:0]            typ;
    logic [15:0]            flags;
  } entry_t;
endpackage
`default_nettype wire

FILE: src/skpt_ram.sv
// ----------------------------------------------------------------------------
// skpt_ram
// Generic single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module skpt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule
`default_nettype wire

FILE: src/sorted_keyed_property_table.sv
// ----------------------------------------------------------------------------
// sorted_keyed_property_table
// Sorted key table: binary search, insert/remove shifting, lookup and clear.
// ----------------------------------------------------------------------------
// Sequence: each binary search step reads the middle entry (SRead) and compares
// it (SCmp), at most floor(log2(count)) + 1 steps; the entry at the lower bound
// is then read (SHit) and acted on (SAct); an insert or remove moves one entry per
// SShRd/SShWr pair; SFinal strobes the result on valid_o; busy high throughout.
// The longest request is a remove at the bottom of a full table. Receiver cannot
// stall. Reset clears count and control; RAM entries at or above count are unused.
`default_nettype none
module sorted_keyed_property_table (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  req_type_i,
  input  wire logic [31:0] key_i,
  input  wire logic [63:0] payload_in_i,
  input  wire logic [31:0] type_in_i,
  input  wire logic [15:0] flags_in_i,
  output logic             valid_o,
  output logic [2:0]       status_o,
  output logic             hit_o,
  output logic [63:0]      payload_out_o,
  output logic [31:0]      type_out_o,
  output logic [15:0]      flags_out_o,
  output logic [6:0]       fill_level_o
);
  import skpt_pkg::*;

  localparam logic [2:0] SIdle  = 3'd0;
  localparam logic [2:0] SRead  = 3'd1;
  localparam logic [2:0] SCmp   = 3'd2;
  localparam logic [2:0] SHit   = 3'd3;
  localparam logic [2:0] SAct   = 3'd4;
  localparam logic [2:0] SShRd  = 3'd5;
  localparam logic [2:0] SShWr  = 3'd6;
  localparam logic [2:0] SFinal = 3'd7;

  logic [2:0]  st_q, st_d;
  logic [CntW-1:0] cnt_q, cnt_d, lo_q, lo_d, n_q, n_d, sh_q, sh_d;
  logic [1:0]  req_q;
  logic [31:0] key_q;
  logic [PayloadBits-1:0] pay_q;
  logic [31:0] typ_q;
  logic [15:0] flg_q;
  logic        hit_q, hit_d;
  logic        vld_q, vld_d;
  logic [2:0]  sts_q, sts_d;
  entry_t      res_q, res_d;

  logic        we;
  logic [IdxW-1:0] addr;
  entry_t      wdata, rdata;
  logic [EntryW-1:0] rraw;

  skpt_ram #(.Width(EntryW), .Depth(TableDepth)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .addr_i (addr),
    .wdata_i(wdata),
    .rdata_o(rraw)
  );
  assign rdata = entry_t'(rraw);

  logic [CntW-1:0] half, mid;
  logic        copy_ok;
  entry_t      dst, merged;
  assign half = n_q >> 1;
  assign mid  = lo_q + half;

  always_comb begin
    dst = hit_q ? rdata : '0;
    copy_ok = ((flg_q & FlagNonplain) == '0) &&
              (((dst.flags & FlagLock) == '0) || (dst.typ == typ_q));
    merged = dst;
    merged.key = key_q;
    if (copy_ok) begin
      merged.payload = pay_q;
      merged.typ     = typ_q;
      merged.flags   = (flg_q & FlagKeepMask) | (dst.flags & FlagLock);
    end
  end

  always_comb begin
    st_d = st_q; cnt_d = cnt_q; lo_d = lo_q; n_d = n_q; sh_d = sh_q;
    hit_d = hit_q; vld_d = 1'b0; sts_d = sts_q; res_d = res_q;
    we = 1'b0; addr = mid[IdxW-1:0]; wdata = rdata;
    unique case (st_q)
      SIdle: begin
        if (start) begin
          lo_d = '0; n_d = cnt_q; hit_d = 1'b0;
          st_d = SRead;
        end
      end
      SRead: begin
        if (n_q == '0) begin
          addr = lo_q[IdxW-1:0];
          st_d = SHit;
        end else begin
          st_d = SCmp;
        end
      end
      SCmp: begin
        if (rdata.key < key_q) begin
          lo_d = mid + 1'b1; n_d = n_q - half - 1'b1;
        end else begin
          n_d = half;
        end
        st_d = SRead;
      end
      SHit: begin
        // rdata holds entry at lower bound
        addr  = lo_q[IdxW-1:0];
        hit_d = (lo_q < cnt_q) && (rdata.key == key_q);
        st_d  = SAct;
      end
      SAct: begin
        addr = lo_q[IdxW-1:0];
        res_d = '0; sts_d = StOk;
        st_d = SFinal;
        unique case (req_q)
          ReqSet: begin
            if (hit_q) begin
              we = copy_ok; wdata = merged;
              sts_d = copy_ok ? StOk : StConvert;
              res_d = copy_ok ? merged : dst;
            end else if (cnt_q >= CntW'(TableDepth)) begin
              sts_d = StFull;
            end else if (cnt_q == lo_q) begin
              we = 1'b1; wdata = merged;
              cnt_d = cnt_q + 1'b1;
              sts_d = copy_ok ? StInserted : StConvert;
              res_d = merged;
            end else begin
              sh_d = cnt_q; st_d = SShRd; // shift up from top
            end
          end
          ReqRemove: begin
            if (hit_q) begin
              sts_d = StRemoved;
              if (lo_q + 1'b1 >= cnt_q) begin
                cnt_d = cnt_q - 1'b1;
              end else begin
                sh_d = lo_q; st_d = SShRd; // shift down from gap
              end
            end else begin
              sts_d = StNotFound;
            end
          end
          ReqLookup: begin
            if (hit_q) res_d = rdata;
            else sts_d = StNotFound;
          end
          default: cnt_d = '0;
        endcase
        if (st_d == SFinal) vld_d = 1'b1;
      end
      SShRd: begin
        addr = (req_q == ReqSet) ? IdxW'(sh_q - 1'b1) : IdxW'(sh_q + 1'b1);
        st_d = SShWr;
      end
      SShWr: begin
        addr = sh_q[IdxW-1:0];
        we = 1'b1; wdata = rdata;
        if (req_q == ReqSet) begin
          sh_d = sh_q - 1'b1;
          if (sh_q - 1'b1 == lo_q) begin
            st_d = SFinal;
            // new entry starts zero
            sts_d = copy_ok ? StInserted : StConvert;
            res_d = merged;
            cnt_d = cnt_q + 1'b1;
            vld_d = 1'b1;
          end else st_d = SShRd;
        end else begin
          sh_d = sh_q + 1'b1;
          if (sh_q + 2'd2 >= cnt_q) begin
            cnt_d = cnt_q - 1'b1; vld_d = 1'b1; st_d = SFinal;
          end else st_d = SShRd;
        end
      end
      default: begin
        // SFinal: write the new entry after any insert, shifted or not
        if (vld_q && req_q == ReqSet && sts_q != StFull && sts_q != StOk &&
            !hit_q) begin
          addr = lo_q[IdxW-1:0]; we = 1'b1; wdata = res_q;
        end
        st_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle; cnt_q <= '0; vld_q <= 1'b0;
    end else begin
      st_q <= st_d; cnt_q <= cnt_d; vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q <= lo_d; n_q <= n_d; sh_q <= sh_d; hit_q <= hit_d;
    sts_q <= sts_d; res_q <= res_d;
    if (st_q == SIdle && start) begin
      req_q <= req_type_i; key_q <= key_i; pay_q <= payload_in_i[PayloadBits-1:0];
      typ_q <= type_in_i; flg_q <= flags_in_i;
    end
  end

  assign busy          = (st_q != SIdle);
  assign valid_o       = vld_q;
  assign status_o      = sts_q;
  assign hit_o         = hit_q;
  assign payload_out_o = 64'(res_q.payload);
  assign type_out_o    = res_q.typ;
  assign flags_out_o   = res_q.flags;
  assign fill_level_o  = 7'(cnt_q);
endmodule
`default_nettype wire

FILE: tb/tb_sorted_keyed_property_table.sv
// ----------------------------------------------------------------------------
// tb_sorted_keyed_property_table
// Self-checking bench for the sorted keyed property table: directed corner
// requests, a fill to capacity, then random request streams, each result
// checked against an in-bench table predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_sorted_keyed_property_table;
  import skpt_pkg::*;

  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned DrainCycles   = 2 * TableDepth + 40;

  typedef struct packed {
    logic [2:0]  status;
    logic        hit;
    logic [63:0] payload;
    logic [31:0] typ;
    logic [15:0] flags;
    logic [6:0]  count;
  } reply_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  req_type;
  logic [31:0] key;
  logic [63:0] payload_in;
  logic [31:0] type_in;
  logic [15:0] flags_in;
  logic        valid;
  logic [2:0]  status;
  logic        hit;
  logic [63:0] payload_out;
  logic [31:0] type_out;
  logic [15:0] flags_out;
  logic [6:0]  fill_level;

  // predictor copy of the table
  logic [31:0] tbl_key   [TableDepth];
  logic [63:0] tbl_pay   [TableDepth];
  logic [31:0] tbl_typ   [TableDepth];
  logic [15:0] tbl_flags [TableDepth];
  int unsigned tbl_fill;

  reply_t      pending_replies[$];
  int          errors;
  int          send_idle_pct;
  int unsigned quiet_cycles;
  logic [31:0] key_pool[96];

  sorted_keyed_property_table i_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .start        (start),
    .busy         (busy),
    .req_type_i   (req_type),
    .key_i        (key),
    .payload_in_i (payload_in),
    .type_in_i    (type_in),
    .flags_in_i   (flags_in),
    .valid_o      (valid),
    .status_o     (status),
    .hit_o        (hit),
    .payload_out_o(payload_out),
    .type_out_o   (type_out),
    .flags_out_o  (flags_out),
    .fill_level_o (fill_level)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit try_copy(int unsigned i, logic [63:0] p, logic [31:0] t,
                                  logic [15:0] f);
    logic [15:0] dst;
    dst = tbl_flags[i];
    if ((f & FlagNonplain) == 16'h0 && ((dst & FlagLock) == 16'h0 || tbl_typ[i] == t)) begin
      tbl_pay[i]   = p;
      tbl_typ[i]   = t;
      tbl_flags[i] = (f & FlagKeepMask) | (dst & FlagLock);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic reply_t table_apply(logic [1:0] r, logic [31:0] k, logic [63:0] p,
                                         logic [31:0] t, logic [15:0] f);
    reply_t      rep;
    int unsigned pos;
    bit          found;
    rep = '0;
    pos = 0;
    while (pos < tbl_fill && tbl_key[pos] < k) pos++;
    found = pos < tbl_fill && tbl_key[pos] == k;
    rep.hit = found;
    case (r)
      ReqSet: begin
        if (found) begin
          rep.status = try_copy(pos, p, t, f) ? StOk : StConvert;
        end else if (tbl_fill >= TableDepth) begin
          rep.status = StFull;
        end else begin
          for (int unsigned i = tbl_fill; i > pos; i--) begin
            tbl_key[i]   = tbl_key[i-1];
            tbl_pay[i]   = tbl_pay[i-1];
            tbl_typ[i]   = tbl_typ[i-1];
            tbl_flags[i] = tbl_flags[i-1];
          end
          tbl_key[pos]   = k;
          tbl_pay[pos]   = '0;
          tbl_typ[pos]   = '0;
          tbl_flags[pos] = '0;
          tbl_fill++;
          rep.status = try_copy(pos, p, t, f) ? StInserted : StConvert;
        end
        if (rep.status != StFull) begin
          rep.payload = tbl_pay[pos];
          rep.typ     = tbl_typ[pos];
          rep.flags   = tbl_flags[pos];
        end
      end
      ReqRemove: begin
        if (found) begin
          for (int unsigned i = pos; i + 1 < tbl_fill; i++) begin
            tbl_key[i]   = tbl_key[i+1];
            tbl_pay[i]   = tbl_pay[i+1];
            tbl_typ[i]   = tbl_typ[i+1];
            tbl_flags[i] = tbl_flags[i+1];
          end
          tbl_fill--;
          rep.status = StRemoved;
        end else begin
          rep.status = StNotFound;
        end
      end
      ReqLookup: begin
        if (found) begin
          rep.status  = StOk;
          rep.payload = tbl_pay[pos];
          rep.typ     = tbl_typ[pos];
          rep.flags   = tbl_flags[pos];
        end else begin
          rep.status = StNotFound;
        end
      end
      default: begin
        tbl_fill   = 0;
        rep.status = StOk;
      end
    endcase
    rep.count = tbl_fill[6:0];
    return rep;
  endfunction

  // Drives one request and holds it until accepted; start stays high afterwards unless a random idle gap drops it.
  task automatic send_request(logic [1:0] r, logic [31:0] k, logic [63:0] p,
                              logic [31:0] t, logic [15:0] f);
    start      <= 1'b1;
    req_type   <= r;
    key        <= k;
    payload_in <= p;
    type_in    <= t;
    flags_in   <= f;
    do @(posedge clk); while (busy);
    pending_replies.push_back(table_apply(r, k, p, t, f));
    if ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    reply_t want;
    if (rst_n && valid) begin
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected result status=%0d", $time, status);
        errors++;
      end else begin
        want = pending_replies.pop_front();
        if (status !== want.status) begin
          $display("%0t: status exp %0d got %0d", $time, want.status, status);
          errors++;
        end
        if (hit !== want.hit) begin
          $display("%0t: hit exp %0d got %0d", $time, want.hit, hit);
          errors++;
        end
        if (payload_out !== want.payload) begin
          $display("%0t: payload exp %h got %h", $time, want.payload, payload_out);
          errors++;
        end
        if (type_out !== want.typ) begin
          $display("%0t: type exp %h got %h", $time, want.typ, type_out);
          errors++;
        end
        if (flags_out !== want.flags) begin
          $display("%0t: flags exp %h got %h", $time, want.flags, flags_out);
          errors++;
        end
        if (fill_level !== want.count) begin
          $display("%0t: count exp %0d got %0d", $time, want.count, fill_level);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || valid || (start && !busy)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("tb_sorted_keyed_property_table: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic test_directed();
    send_request(ReqLookup, 32'h10, '0, '0, '0);
    send_request(ReqRemove, 32'h10, '0, '0, '0);
    send_request(ReqClear, 32'h10, '0, '0, '0);
    send_request(ReqSet, 32'h0, 64'hffff_ffff_ffff_ffff, 32'hffff_ffff, 16'hfff7);
    send_request(ReqSet, 32'hffff_ffff, 64'h0, 32'h0, 16'h0);
    send_request(ReqSet, 32'h8000_0000, 64'h1234_5678_9abc_def0, 32'h7, 16'h0002);
    // entry not locked (keep mask clears the lock bit), different type: accepted
    send_request(ReqSet, 32'h8000_0000, 64'h1, 32'h8, 16'h0);
    // same type again: copy accepted, lock bit stays clear
    send_request(ReqSet, 32'h8000_0000, 64'h2, 32'h7, 16'h0030);
    // non-plain source on an existing entry
    send_request(ReqSet, 32'h0, 64'h3, 32'h3, 16'h0008);
    // non-plain source on a new key: inserted as all zero
    send_request(ReqSet, 32'h40, 64'h5, 32'h5, 16'hffff);
    send_request(ReqLookup, 32'h40, '0, '0, '0);
    send_request(ReqLookup, 32'hffff_ffff, '0, '0, '0);
    send_request(ReqLookup, 32'h0, '0, '0, '0);
    send_request(ReqRemove, 32'h0, '0, '0, '0);
    send_request(ReqRemove, 32'hffff_ffff, '0, '0, '0);
    send_request(ReqLookup, 32'h41, '0, '0, '0);
    send_request(ReqClear, 32'h40, '0, '0, '0);
    send_request(ReqClear, 32'h40, '0, '0, '0);
    wait_drained();
  endtask

  task automatic test_fill_to_full();
    for (int i = 0; i < TableDepth + 2; i++) begin
      send_request(ReqSet, $urandom, {$urandom, $urandom}, $urandom,
                   16'($urandom) & 16'hfff7);
    end
    send_request(ReqLookup, tbl_key[TableDepth-1], '0, '0, '0);
    send_request(ReqRemove, tbl_key[0], '0, '0, '0);
    send_request(ReqRemove, tbl_key[TableDepth/2], '0, '0, '0);
    send_request(ReqClear, '0, '0, '0, '0);
    wait_drained();
  endtask

  task automatic test_random(int n);
    logic [1:0]  r;
    logic [31:0] k;
    logic [15:0] f;
    int          pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 45)      r = ReqSet;
      else if (pick < 70) r = ReqRemove;
      else if (pick < 99) r = ReqLookup;
      else                r = ReqClear;
      k = ($urandom_range(9) == 0) ? $urandom : key_pool[$urandom_range(95)];
      f = 16'($urandom);
      if ($urandom_range(2) != 0) f[3] = 1'b0;
      send_request(r, k, {$urandom, $urandom},
                   ($urandom_range(1) == 0) ? $urandom_range(3) : $urandom, f);
    end
  endtask

  initial begin
    errors        = 0;
    send_idle_pct = 0;
    rst_n         = 1'b0;
    start         = 1'b0;
    req_type      = ReqLookup;
    key           = '0;
    payload_in    = '0;
    type_in       = '0;
    flags_in      = '0;
    tbl_fill      = 0;
    for (int i = 0; i < 96; i++) key_pool[i] = $urandom;
    key_pool[0] = 32'h0;
    key_pool[1] = 32'hffff_ffff;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 26;
    test_directed();
    test_fill_to_full();
    test_random(600);
    wait_drained();
    send_idle_pct = 74;
    test_random(600);
    send_idle_pct = 0;
    test_random(600);

    wait_drained();
    repeat (DrainCycles) @(posedge clk);
    if (errors == 0) begin
      $display("tb_sorted_keyed_property_table: done, clean");
    end else begin
      $display("tb_sorted_keyed_property_table: done, errors");
    end
    $finish;
  end
endmodule
